// File: hdl/hbf_pkg.sv
// Package with the types, codes and constants shared by the heartbeat fader.
`default_nettype none
package hbf_pkg;

  localparam int DIV_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int FADE_STEP_W = 9;
  // Scale of the tick-length reciprocal; exact for 11-bit periods and ticks up to 100 ms.
  localparam int TICK_RECIP_SHIFT = 18;

  localparam logic [1:0] REQ_READING = 2'd0;
  localparam logic [1:0] REQ_FADE = 2'd1;
  localparam logic [1:0] REQ_PULSE = 2'd2;

  localparam logic [1:0] CONTACT_FINGER = 2'd3;

  localparam logic [15:0] BPM_MIN = 16'd30;
  localparam logic [15:0] BPM_MAX = 16'd240;
  localparam logic [10:0] PERIOD_SLOW_MS = 11'd2000;
  localparam logic [10:0] PERIOD_FAST_MS = 11'd250;
  localparam logic [10:0] PERIOD_RESET_MS = 11'd1000;
  localparam logic [DIV_W-1:0] MS_PER_MIN = 16'd60000;
  localparam logic [DIV_W-1:0] FADE_FULL_SCALE = 16'd256;

  localparam logic [7:0] LEVEL_FULL = 8'hFF;
  localparam logic [7:0] LEVEL_OFF = 8'h00;
  localparam logic [7:0] FLAG_CONTACT_SUP = 8'h04;
  localparam logic [7:0] FLAG_FINGER = 8'h02;
  localparam logic [7:0] BPM_SAT = 8'hFF;
  localparam logic [3:0] EXT_DISABLED = 4'd8;

  typedef struct packed {
    logic [1:0]        req_type;
    logic              sensor_ok;
    logic [1:0]        contact_status;
    logic [6:0]        confidence;
    logic [15:0]       rate_bpm;
    logic signed [7:0] hub_code;
  } hbf_req_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [10:0] pulse_period_ms;
    logic [7:0]  measure_flags;
    logic [7:0]  measure_bpm;
    logic [3:0]  ext_index;
  } hbf_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PERIOD_DIV,
    ST_STEP_DIV,
    ST_DONE
  } hbf_state_t;

  typedef enum logic [1:0] {
    DIV_PERIOD,
    DIV_STEP
  } hbf_div_sel_t;

  typedef struct packed {
    logic         accept;
    logic         div_start;
    hbf_div_sel_t div_sel;
    logic         wr_period;
    logic         wr_step;
    logic         load_out;
  } hbf_cmd_t;

  typedef struct packed {
    logic need_period_div;
    logic is_pulse;
    logic div_done;
  } hbf_stat_t;

  // With decoding enabled, codes 0 and 1 map to themselves, -6..-1 map to 2..7, anything else is unknown.
  function automatic logic [3:0] decode_ext(input logic [7:0] code, input logic en);
    logic [3:0] idx;
    begin
      if (!en) begin
        idx = EXT_DISABLED;
      end else if (code == 8'h00 || code == 8'h01) begin
        idx = code[3:0];
      end else if (code >= 8'hFA) begin
        idx = 4'(code - 8'hF8);
      end else begin
        idx = EXT_DISABLED;
      end
      return idx;
    end
  endfunction

endpackage
`default_nettype wire

// File: hdl/hbf_ifs.sv
// Valid/ready channel interfaces for requests, results and the configuration write.
`default_nettype none
interface hbf_req_if;
  import hbf_pkg::*;
  logic     valid;
  logic     ready;
  hbf_req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface hbf_rsp_if;
  import hbf_pkg::*;
  logic     valid;
  logic     ready;
  hbf_rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface hbf_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/hbf_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module hbf_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [hbf_pkg::DIV_W-1:0] dividend,
  input  wire logic [hbf_pkg::DIV_W-1:0] divisor,
  output logic                          done,
  output logic [hbf_pkg::DIV_W-1:0]     quotient
);
  import hbf_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       trial;

  assign rem_sh = {rem, quotient[DIV_W-1]};
  assign trial = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= DIV_CNT_W'(DIV_W - 1);
        rem <= '0;
        quotient <= dividend;
        dvs <= divisor;
      end else if (busy) begin
        // A clear top bit of the trial difference means the divisor fits.
        if (!trial[DIV_W]) begin
          rem <= trial[DIV_W-1:0];
          quotient <= {quotient[DIV_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DIV_W-1:0];
          quotient <= {quotient[DIV_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - DIV_CNT_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/hbf_datapath.sv
// Datapath: held sensor data, LED levels, pulse period, fade step and result register.
`default_nettype none
module hbf_datapath #(
  parameter int FADE_TICK_MS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hbf_pkg::hbf_req_t req_data,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_data,
  input  wire hbf_pkg::hbf_cmd_t cmd,
  output hbf_pkg::hbf_stat_t     stat,
  output hbf_pkg::hbf_rsp_t      rsp_data
);
  import hbf_pkg::*;

  // The tick count is the period times a rounded-up reciprocal of the tick length.
  localparam int TICK_RECIP_W = TICK_RECIP_SHIFT + 1;
  localparam int TICK_PROD_W = TICK_RECIP_SHIFT + 11;
  localparam logic [TICK_RECIP_W-1:0] TICK_RECIP =
    TICK_RECIP_W'(((1 << TICK_RECIP_SHIFT) + FADE_TICK_MS - 1) / FADE_TICK_MS);

  logic                   ext_enable;
  logic                   link_ok;
  logic [1:0]             held_status;
  logic [6:0]             held_confidence;
  logic [15:0]            held_bpm;
  logic [10:0]            period_ms;
  logic [7:0]             red_level;
  logic [7:0]             green_level;
  logic [7:0]             blue_level;
  logic [FADE_STEP_W-1:0] fade_step;
  logic [3:0]             held_ext_index;

  logic [DIV_W-1:0]       div_dividend;
  logic [DIV_W-1:0]       div_divisor;
  logic [DIV_W-1:0]       div_q;
  logic [DIV_W-1:0]       ticks;
  logic [TICK_PROD_W-1:0] tick_prod;
  logic [10:0]            tick_cnt;
  logic                   div_done;
  logic                   finger_rate;
  logic                   held_rate_ok;

  function automatic logic [7:0] fade_one(input logic [7:0] level,
                                          input logic [FADE_STEP_W-1:0] step);
    logic [FADE_STEP_W-1:0] lvl;
    begin
      lvl = FADE_STEP_W'(level);
      return (lvl >= step) ? 8'(lvl - step) : LEVEL_OFF;
    end
  endfunction

  assign finger_rate = req_data.sensor_ok && req_data.contact_status == CONTACT_FINGER &&
                       req_data.confidence != '0 && req_data.rate_bpm != '0;
  assign held_rate_ok = held_confidence != '0 && held_bpm != '0;

  assign stat.need_period_div = req_data.req_type == REQ_READING && finger_rate &&
                                req_data.rate_bpm >= BPM_MIN &&
                                req_data.rate_bpm <= BPM_MAX;
  assign stat.is_pulse = req_data.req_type == REQ_PULSE;
  assign stat.div_done = div_done;

  assign tick_prod = TICK_PROD_W'(period_ms) * TICK_PROD_W'(TICK_RECIP);
  assign tick_cnt = tick_prod[TICK_RECIP_SHIFT +: 11];

  // A zero tick count is taken as one.
  assign ticks = (tick_cnt == '0) ? DIV_W'(1) : DIV_W'(tick_cnt);

  always_comb begin
    case (cmd.div_sel)
      DIV_PERIOD: begin
        div_dividend = MS_PER_MIN;
        div_divisor = req_data.rate_bpm;
      end
      DIV_STEP: begin
        div_dividend = FADE_FULL_SCALE;
        div_divisor = ticks;
      end
      default: begin
        div_dividend = MS_PER_MIN;
        div_divisor = DIV_W'(1);
      end
    endcase
  end

  hbf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_enable <= 1'b1;
      link_ok <= 1'b0;
      held_status <= '0;
      held_confidence <= '0;
      held_bpm <= '0;
      period_ms <= PERIOD_RESET_MS;
      red_level <= LEVEL_OFF;
      green_level <= LEVEL_OFF;
      blue_level <= LEVEL_OFF;
      fade_step <= '0;
      held_ext_index <= EXT_DISABLED;
    end else begin
      if (cfg_valid) begin
        ext_enable <= cfg_data;
      end
      if (cmd.accept) begin
        case (req_data.req_type)
          REQ_READING: begin
            if (!req_data.sensor_ok) begin
              link_ok <= 1'b0;
            end else begin
              link_ok <= 1'b1;
              held_status <= req_data.contact_status;
              held_confidence <= req_data.confidence;
              held_bpm <= req_data.rate_bpm;
              held_ext_index <= decode_ext($unsigned(req_data.hub_code), ext_enable);
              if (finger_rate && req_data.rate_bpm < BPM_MIN) begin
                period_ms <= PERIOD_SLOW_MS;
              end else if (finger_rate && req_data.rate_bpm > BPM_MAX) begin
                period_ms <= PERIOD_FAST_MS;
              end
            end
          end
          REQ_FADE: begin
            red_level <= fade_one(red_level, fade_step);
            green_level <= fade_one(green_level, fade_step);
            blue_level <= fade_one(blue_level, fade_step);
          end
          REQ_PULSE: begin
            if (!link_ok) begin
              red_level <= LEVEL_FULL;
              green_level <= LEVEL_FULL;
              blue_level <= LEVEL_FULL;
            end else if (held_status == CONTACT_FINGER) begin
              red_level <= held_rate_ok ? LEVEL_OFF : LEVEL_FULL;
              green_level <= LEVEL_FULL;
              blue_level <= LEVEL_OFF;
            end else begin
              red_level <= LEVEL_FULL;
              green_level <= LEVEL_OFF;
              blue_level <= LEVEL_OFF;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.wr_period) begin
        period_ms <= div_q[10:0];
      end
      if (cmd.wr_step) begin
        fade_step <= div_q[FADE_STEP_W-1:0] + FADE_STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_data.red_out <= red_level;
      rsp_data.green_out <= green_level;
      rsp_data.blue_out <= blue_level;
      rsp_data.pulse_period_ms <= period_ms;
      rsp_data.measure_flags <= FLAG_CONTACT_SUP |
                                ((held_status == CONTACT_FINGER) ? FLAG_FINGER : 8'h00);
      rsp_data.measure_bpm <= (held_bpm > 16'(BPM_SAT)) ? BPM_SAT : held_bpm[7:0];
      rsp_data.ext_index <= held_ext_index;
    end
  end

endmodule
`default_nettype wire

// File: hdl/hbf_ctrl.sv
// Controller: sequences acceptance, the divider passes and the result beat.
`default_nettype none
module hbf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  input  wire hbf_pkg::hbf_stat_t stat,
  output hbf_pkg::hbf_cmd_t       cmd
);
  import hbf_pkg::*;

  hbf_state_t state;
  hbf_state_t state_next;
  logic       out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (stat.need_period_div) begin
            state_next = ST_PERIOD_DIV;
          end else if (stat.is_pulse) begin
            state_next = ST_STEP_DIV;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_PERIOD_DIV: begin
        if (stat.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_STEP_DIV: begin
        if (stat.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel = DIV_PERIOD;
    req_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.accept = req_valid;
        cmd.div_start = req_valid && (stat.need_period_div || stat.is_pulse);
        cmd.div_sel = stat.need_period_div ? DIV_PERIOD : DIV_STEP;
      end
      ST_PERIOD_DIV: begin
        cmd.wr_period = stat.div_done;
      end
      ST_STEP_DIV: begin
        cmd.wr_step = stat.div_done;
        cmd.div_sel = DIV_STEP;
      end
      ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_done_only_while_dividing: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == ST_PERIOD_DIV || state == ST_STEP_DIV))
    else $error("divider finished outside a divide state");

  a_load_gives_beat: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp_valid)
    else $error("result load did not present a beat");

  a_stalled_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && rsp_valid && !rsp_ready) |=> state == ST_DONE)
    else $error("result left while the previous beat was stalled");

  a_start_from_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> state == ST_IDLE)
    else $error("divider started from an unexpected state");

endmodule
`default_nettype wire

// File: hdl/heartbeat_led_pulse_fader.sv
// Heartbeat LED fader: sensor readings, pulse events and fade ticks to LED levels.
// A fade tick, a failed reading, a reading that needs no division or an unused code goes
// from acceptance to the result register load; a reading that recomputes the period
// and a pulse event first make one divider pass each, and a stalled output holds the load.
// One request is in work at a time; the next is taken once the result register loads.
// Reset (rst, synchronous) gives period 1000 ms, LEDs off, extended status decoding on.
`default_nettype none
module heartbeat_led_pulse_fader #(
  parameter int FADE_TICK_MS = 10
) (
  input wire logic  clk,
  input wire logic  rst,
  hbf_req_if.sink   req,
  hbf_rsp_if.source rsp,
  hbf_cfg_if.sink   cfg
);
  import hbf_pkg::*;

  hbf_cmd_t  cmd;
  hbf_stat_t stat;

  assign cfg.ready = 1'b1;

  hbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hbf_datapath #(
    .FADE_TICK_MS (FADE_TICK_MS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req.data),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_data  (rsp.data)
  );

endmodule
`default_nettype wire

// File: bench/heartbeat_led_pulse_fader_tb.sv
// Self-checking testbench for the heartbeat LED fader: corner cases, then paced random events.
`default_nettype none
module heartbeat_led_pulse_fader_tb;
  import hbf_pkg::*;

  localparam int FADE_TICK_MS = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;
  localparam int MAX_PRINTED_ERRORS = 40;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] CONTACT_NONE = 2'd0;
  localparam logic [1:0] CONTACT_OBJECT = 2'd1;
  localparam logic [1:0] CONTACT_NOT_FINGER = 2'd2;

  class pulse_fader_scoreboard;
    hbf_rsp_t expected_rsp[$];
    int errors;
    int results_checked;
    int n_reading;
    int n_fade;
    int n_pulse;
    int n_unused;
    int n_cfg;

    bit ext_decode_on;
    bit link_up;
    logic [1:0] status_q;
    logic [6:0] confidence_q;
    logic [15:0] bpm_q;
    logic [10:0] period_q;
    logic [7:0] red_q;
    logic [7:0] green_q;
    logic [7:0] blue_q;
    logic [15:0] step_q;
    logic [3:0] ext_idx_q;

    function new();
      ext_decode_on = 1'b1;
      link_up = 1'b0;
      status_q = '0;
      confidence_q = '0;
      bpm_q = '0;
      period_q = 11'd1000;
      red_q = '0;
      green_q = '0;
      blue_q = '0;
      step_q = '0;
      ext_idx_q = 4'd8;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED_ERRORS)
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function void write_config(logic en);
      ext_decode_on = en;
      n_cfg++;
    endfunction

    // Codes -6..1 are known; negative codes land on indexes 2..7.
    function logic [3:0] ext_index_of(logic signed [7:0] code);
      int v;
      v = int'(code);
      if (!ext_decode_on || v < -6 || v > 1) return 4'd8;
      return (v < 0) ? 4'(v + 8) : 4'(v);
    endfunction

    function logic [7:0] faded(logic [7:0] lvl);
      return (16'(lvl) >= step_q) ? 8'(16'(lvl) - step_q) : 8'd0;
    endfunction

    function void note_event(hbf_req_t r);
      hbf_rsp_t e;
      int ticks;
      case (r.req_type)
        REQ_READING: begin
          n_reading++;
          if (!r.sensor_ok) begin
            link_up = 1'b0;
          end else begin
            link_up = 1'b1;
            status_q = r.contact_status;
            confidence_q = r.confidence;
            bpm_q = r.rate_bpm;
            ext_idx_q = ext_index_of(r.hub_code);
            if (status_q == CONTACT_FINGER && confidence_q != 0 && bpm_q != 0) begin
              if (bpm_q < 30) period_q = 11'd2000;
              else if (bpm_q > 240) period_q = 11'd250;
              else period_q = 11'(60000 / int'(bpm_q));
            end
          end
        end
        REQ_FADE: begin
          n_fade++;
          red_q = faded(red_q);
          green_q = faded(green_q);
          blue_q = faded(blue_q);
        end
        REQ_PULSE: begin
          n_pulse++;
          if (!link_up) begin
            {red_q, green_q, blue_q} = {8'hFF, 8'hFF, 8'hFF};
          end else if (status_q == CONTACT_FINGER) begin
            if (confidence_q != 0 && bpm_q != 0) {red_q, green_q, blue_q} = {8'h00, 8'hFF, 8'h00};
            else {red_q, green_q, blue_q} = {8'hFF, 8'hFF, 8'h00};
          end else begin
            {red_q, green_q, blue_q} = {8'hFF, 8'h00, 8'h00};
          end
          ticks = int'(period_q) / FADE_TICK_MS;
          if (ticks == 0) ticks = 1;
          step_q = 16'(256 / ticks + 1);
        end
        default: n_unused++;
      endcase
      e.red_out = red_q;
      e.green_out = green_q;
      e.blue_out = blue_q;
      e.pulse_period_ms = period_q;
      e.measure_flags = 8'h04 | ((status_q == CONTACT_FINGER) ? 8'h02 : 8'h00);
      e.measure_bpm = (bpm_q > 255) ? 8'hFF : bpm_q[7:0];
      e.ext_index = ext_idx_q;
      expected_rsp.push_back(e);
    endfunction

    task cmp(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0d, expected %0d",
                         results_checked, name, got, want));
    endtask

    task check_result(hbf_rsp_t got);
      hbf_rsp_t want;
      if (expected_rsp.size() == 0) begin
        report($sformatf("result beat with no event outstanding: %p", got));
        return;
      end
      want = expected_rsp.pop_front();
      results_checked++;
      cmp("red_out", 16'(got.red_out), 16'(want.red_out));
      cmp("green_out", 16'(got.green_out), 16'(want.green_out));
      cmp("blue_out", 16'(got.blue_out), 16'(want.blue_out));
      cmp("pulse_period_ms", 16'(got.pulse_period_ms), 16'(want.pulse_period_ms));
      cmp("measure_flags", 16'(got.measure_flags), 16'(want.measure_flags));
      cmp("measure_bpm", 16'(got.measure_bpm), 16'(want.measure_bpm));
      cmp("ext_index", 16'(got.ext_index), 16'(want.ext_index));
    endtask
  endclass

  logic clk;
  logic rst;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int items_sent = 0;

  pulse_fader_scoreboard sb = new();

  hbf_req_if req_bus();
  hbf_rsp_if rsp_bus();
  hbf_cfg_if cfg_bus();

  heartbeat_led_pulse_fader #(.FADE_TICK_MS(FADE_TICK_MS)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus),
    .cfg(cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, plus a long counted hold-off when one is requested.
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else if (hold_request > 0) begin
        hold_left = hold_request - 1;
        hold_request = 0;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Results are checked before the same edge's request is noted; a result never belongs
  // to a request accepted on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) sb.check_result(rsp_bus.data);
      if (req_bus.valid && req_bus.ready) sb.note_event(req_bus.data);
      if (cfg_bus.valid && cfg_bus.ready) sb.write_config(cfg_bus.data);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat on any channel for %0d cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Valid is left high after a beat so back-to-back items need no second assignment.
  task automatic send_req(input hbf_req_t item);
    if ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.data <= item;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    items_sent++;
  endtask

  // One edge passes first so that the last accepted beat is already on the scoreboard.
  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic en);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= en;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic hbf_req_t random_fields();
    hbf_req_t r;
    r.req_type = 2'($urandom_range(3));
    r.sensor_ok = 1'($urandom_range(1));
    r.contact_status = 2'($urandom_range(3));
    r.confidence = 7'($urandom_range(100));
    r.rate_bpm = 16'($urandom);
    r.hub_code = 8'($urandom);
    return r;
  endfunction

  // Fade ticks and pulses carry random payload, which the block must ignore.
  function automatic hbf_req_t bare_event(input logic [1:0] kind);
    hbf_req_t r;
    r = random_fields();
    r.req_type = kind;
    return r;
  endfunction

  function automatic hbf_req_t reading(input logic ok, input logic [1:0] contact,
                                       input int conf, input int bpm, input int ext);
    hbf_req_t r;
    r.req_type = REQ_READING;
    r.sensor_ok = ok;
    r.contact_status = contact;
    r.confidence = 7'(conf);
    r.rate_bpm = 16'(bpm);
    r.hub_code = 8'(ext);
    return r;
  endfunction

  // Mostly a good finger reading with a plausible rate and a known status code.
  function automatic hbf_req_t random_reading();
    hbf_req_t r;
    int pick;
    int code;
    r = bare_event(REQ_READING);
    r.sensor_ok = ($urandom_range(9) != 0);
    if ($urandom_range(99) < 85) r.contact_status = CONTACT_FINGER;
    r.confidence = ($urandom_range(19) != 0) ? 7'($urandom_range(1, 100)) : 7'd0;
    pick = $urandom_range(9);
    if (pick < 7) r.rate_bpm = 16'($urandom_range(30, 240));
    else if (pick == 7) r.rate_bpm = 16'($urandom_range(0, 29));
    else if (pick == 8) r.rate_bpm = 16'($urandom_range(241, 400));
    code = $urandom_range(7);
    if ($urandom_range(3) != 0) r.hub_code = 8'(code - 6);
    return r;
  endfunction

  // Mostly a heartbeat: reading, pulse, then 2 to 30 fade ticks; otherwise one random event.
  task automatic run_phase(input int n, input int src_pct, input int snk_pct);
    int stop_at;
    stop_at = items_sent + n;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        send_req(random_reading());
        send_req(bare_event(REQ_PULSE));
        repeat ($urandom_range(2, 30)) send_req(bare_event(REQ_FADE));
      end else begin
        send_req(random_fields());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.data = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Fade before any pulse keeps levels, then a pulse with the link still down.
    send_req(bare_event(REQ_FADE));
    send_req(bare_event(REQ_PULSE));
    send_req(bare_event(REQ_FADE));
    send_req(bare_event(REQ_UNUSED));
    send_req(reading(1'b0, CONTACT_FINGER, 80, 70, 0));
    send_req(reading(1'b1, CONTACT_FINGER, 0, 100, 0));
    send_req(bare_event(REQ_PULSE));
    send_req(reading(1'b1, CONTACT_FINGER, 100, 0, 1));
    send_req(reading(1'b1, CONTACT_FINGER, 1, 29, -6));
    send_req(bare_event(REQ_PULSE));
    send_req(bare_event(REQ_FADE));
    send_req(reading(1'b1, CONTACT_FINGER, 55, 30, -1));
    send_req(reading(1'b1, CONTACT_FINGER, 64, 240, -7));
    send_req(bare_event(REQ_PULSE));
    send_req(bare_event(REQ_FADE));
    send_req(reading(1'b1, CONTACT_FINGER, 99, 241, 2));
    send_req(reading(1'b1, CONTACT_FINGER, 100, 65535, -128));
    send_req(reading(1'b1, CONTACT_NOT_FINGER, 42, 255, 127));
    send_req(bare_event(REQ_PULSE));
    send_req(reading(1'b1, CONTACT_OBJECT, 63, 256, -3));
    send_req(reading(1'b1, CONTACT_NONE, 10, 60, 0));
    send_req(reading(1'b0, CONTACT_NONE, 0, 0, 0));
    send_req(bare_event(REQ_PULSE));
    drain();
    write_cfg(1'b0);
    send_req(reading(1'b1, CONTACT_FINGER, 90, 61, -3));
    send_req(reading(1'b1, CONTACT_FINGER, 90, 120, 1));
    drain();
    write_cfg(1'b1);

    // The first phase opens with a long output stall while the source keeps requests offered.
    hold_request = LONG_HOLD_CYCLES;
    run_phase(PHASE_ITEMS, 0, 0);
    drain();
    write_cfg(1'b0);
    run_phase(PHASE_ITEMS, 65, 0);
    drain();
    write_cfg(1'b1);
    run_phase(PHASE_ITEMS, 0, 65);
    drain();
    write_cfg(1'($urandom_range(1)));
    run_phase(PHASE_ITEMS, 38, 38);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.expected_rsp.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_rsp.size()));
    $display("Exercised %0d readings, %0d pulses, %0d fade ticks and %0d unused codes.",
             sb.n_reading, sb.n_pulse, sb.n_fade, sb.n_unused);
    $display("%0d config writes, %0d results checked, four pacing mixes, %0d-cycle hold.",
             sb.n_cfg, sb.results_checked, LONG_HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
